@@ hdl/wildcard_byte_pattern_scanner_assert.svh @@
// Assertion macros for the wildcard byte pattern scanner.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define WBPS_ASSERT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset
`define WBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WBPS_ASSERT(name, clk, rst_n, ante, cons, msg)
`define WBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/wbps_pkg.sv @@
// Shared constants, types and helpers for the wildcard byte pattern scanner.
// No dependencies.
package wbps_pkg;

	// Sizing
	localparam int MAX_PATTERN       = 16;
	localparam int OFFSET_BITS       = 32;
	localparam int REG_PATTERN_BYTES = 16;
	localparam int PATTERN_CAP       = (MAX_PATTERN < REG_PATTERN_BYTES) ?
		MAX_PATTERN : REG_PATTERN_BYTES;
	localparam int LEN_BITS          = $clog2(PATTERN_CAP + 1);
	localparam int WIN_IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int MATCH_OFFSET_BITS = 32;

	// Configuration port
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_LEN_BITS   = 5;
	localparam int CARE_BITS      = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK    = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd3;

	localparam logic [CARE_BITS-1:0]    CARE_MASK_RESET   = '1;
	localparam logic [CFG_LEN_BITS-1:0] PATTERN_LEN_RESET = 5'd1;

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	typedef logic [7:0]             byte_t;
	typedef logic [LEN_BITS-1:0]    len_t;
	typedef logic [OFFSET_BITS-1:0] count_t;

	// Length in use: zero reads as one, anything above the cap is clamped
	function automatic len_t effective_length(input logic [CFG_LEN_BITS-1:0] raw);
		len_t len;
		if (raw == '0) begin
			len = len_t'(1);
		end else if (32'(raw) > PATTERN_CAP) begin
			len = len_t'(PATTERN_CAP);
		end else begin
			len = len_t'(raw);
		end
		return len;
	endfunction

endpackage

@@ hdl/wbps_if.sv @@
// Stream interfaces for the wildcard byte pattern scanner: byte input, result output.
// Depends on wbps_pkg.
interface wbps_in_if;
	logic                 valid;
	logic                 ready;
	wbps_pkg::byte_t      data_byte;
	logic                 last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     found;
	logic [wbps_pkg::MATCH_OFFSET_BITS-1:0]   match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

@@ hdl/wildcard_byte_pattern_scanner.sv @@
// Wildcard byte pattern scanner: sliding window compare against a masked pattern.
// An input beat passes the input register, then the result register, on its way to the result beat.
// Throughput: one byte per cycle while the result side does not stall; the window compare is a single registered pass.
// Reset (arst_n low, async): config returns to defaults, region count, match flag and valids clear.
// Depends on wbps_pkg, wbps_if and wildcard_byte_pattern_scanner_assert.svh.
`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	wbps_in_if.sink                                in_ch,
	wbps_out_if.source                             out_ch
);

	// Configuration registers
	logic [63:0]                           pat_low_q;
	logic [63:0]                           pat_high_q;
	logic [wbps_pkg::CARE_BITS-1:0]        care_q;
	logic [wbps_pkg::CFG_LEN_BITS-1:0]     len_cfg_q;

	// Input stage
	logic                                  valid_s1;
	wbps_pkg::byte_t                       data_s1;
	logic                                  last_s1;

	// Region state
	wbps_pkg::byte_t                       window_q [wbps_pkg::MAX_PATTERN];
	wbps_pkg::count_t                      count_q;
	logic                                  match_done_q;

	// Result register
	logic                                  out_valid_q;
	logic                                  out_found_q;
	logic [wbps_pkg::MATCH_OFFSET_BITS-1:0] out_offset_q;

	// Compare path
	wbps_pkg::byte_t                       win_next [wbps_pkg::MAX_PATTERN];
	wbps_pkg::count_t                      count_next;
	wbps_pkg::count_t                      start_pos;
	wbps_pkg::len_t                        len_eff;
	logic [127:0]                          pat_all;
	logic                                  window_ok;
	logic                                  hit;
	logic                                  emit;
	logic                                  adv;

	// Config write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= wbps_pkg::CARE_MASK_RESET;
			len_cfg_q  <= wbps_pkg::PATTERN_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:  pat_low_q  <= cfg_wdata[63:0];
				wbps_pkg::REG_PATTERN_HIGH: pat_high_q <= cfg_wdata[63:0];
				wbps_pkg::REG_CARE_MASK:    care_q     <= cfg_wdata[wbps_pkg::CARE_BITS-1:0];
				wbps_pkg::REG_PATTERN_LEN:  len_cfg_q  <= cfg_wdata[wbps_pkg::CFG_LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the result register is free or being drained
	assign adv          = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Shifted window, saturating count and masked compare
	assign len_eff = wbps_pkg::effective_length(len_cfg_q);
	assign pat_all = {pat_high_q, pat_low_q};

	always_comb begin
		win_next[0] = data_s1;
		for (int i = 1; i < wbps_pkg::MAX_PATTERN; i++) begin
			win_next[i] = window_q[i-1];
		end
	end

	assign count_next = (count_q == wbps_pkg::COUNT_MAX) ? count_q
		: count_q + wbps_pkg::count_t'(1);
	assign start_pos  = count_next - wbps_pkg::count_t'(len_eff);

	// Pattern byte k lines up with window slot len-1-k (slot 0 is newest)
	always_comb begin
		logic [wbps_pkg::WIN_IDX_BITS-1:0] slot;
		window_ok = 1'b1;
		for (int k = 0; k < wbps_pkg::PATTERN_CAP; k++) begin
			slot = wbps_pkg::WIN_IDX_BITS'(32'(len_eff) - 32'd1 - k);
			if ((k < 32'(len_eff)) && care_q[k] && (win_next[slot] != pat_all[8*k +: 8])) begin
				window_ok = 1'b0;
			end
		end
	end

	assign hit  = !match_done_q && (count_next >= wbps_pkg::count_t'(len_eff)) && window_ok;
	assign emit = hit || (last_s1 && !match_done_q);

	// Region state update
	always_ff @(posedge clk) begin
		if (adv && !match_done_q) begin
			window_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			match_done_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				count_q      <= '0;
				match_done_q <= 1'b0;
			end else if (!match_done_q) begin
				count_q      <= count_next;
				match_done_q <= hit;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_found_q  <= hit;
			out_offset_q <= hit ? wbps_pkg::MATCH_OFFSET_BITS'(start_pos) : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = out_found_q;
	assign out_ch.match_offset = out_offset_q;

	// Checks
	`WBPS_ASSERT(a_miss_offset_zero, clk, arst_n, out_valid_q && !out_found_q,
		out_offset_q == '0, "miss result carries a nonzero offset")
	`WBPS_ASSERT(a_match_reported, clk, arst_n, $rose(match_done_q),
		out_valid_q && out_found_q, "match flagged without a found result")
	`WBPS_ASSERT_NEXT(a_accept_lands, clk, arst_n, in_ch.valid && in_ch.ready,
		valid_s1, "accepted beat did not land in the input register")

endmodule

@@ bench/tb_wildcard_byte_pattern_scanner.sv @@
// Self-checking testbench for the wildcard byte pattern scanner: predicts one result per region
// and checks every result beat against it, under several flow patterns and pattern settings.
// Depends on wbps_pkg, wbps_if (wbps_in_if, wbps_out_if) and wildcard_byte_pattern_scanner.
module tb_wildcard_byte_pattern_scanner;
	import wbps_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 120;
	localparam int PHASES        = 9;
	localparam int SRC_IDLE_PCT  = 54;
	localparam int SNK_STALL_PCT = 54;
	localparam int BOTH_PCT      = 16;

	// Raw length written in each random phase, including zero and values above the cap
	localparam logic [CFG_LEN_BITS-1:0] LEN_PLAN [PHASES] =
		'{5'd16, 5'd0, 5'd3, 5'd31, 5'd1, 5'd8, 5'd17, 5'd5, 5'd12};

	typedef enum logic [1:0] {FLOW_FULL, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

	typedef struct packed {
		logic                         found;
		logic [MATCH_OFFSET_BITS-1:0] offset;
	} scan_result_t;

	// Region tracker: own copy of window, count and settings; holds expected results in order
	class scan_scoreboard;
		byte_t                      window [MAX_PATTERN];
		count_t                     seen;
		bit                         matched;
		logic [2*CFG_DATA_BITS-1:0] pattern;
		logic [CARE_BITS-1:0]       care;
		logic [CFG_LEN_BITS-1:0]    len_raw;
		scan_result_t               expected_q[$];
		int                         errors;
		int                         hits;
		int                         misses;

		function new();
			pattern = '0;
			care    = CARE_MASK_RESET;
			len_raw = PATTERN_LEN_RESET;
			errors  = 0;
			hits    = 0;
			misses  = 0;
			clear_region();
		endfunction

		function void clear_region();
			int i;
			for (i = 0; i < MAX_PATTERN; i++) window[i] = '0;
			seen    = '0;
			matched = 1'b0;
		endfunction

		// Length in use: zero counts as one, clamped at the cap
		function int span();
			if (len_raw == '0) return 1;
			if (int'(len_raw) > PATTERN_CAP) return PATTERN_CAP;
			return int'(len_raw);
		endfunction

		function byte_t pattern_byte(int k);
			return pattern[8*k +: 8];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_PATTERN_LOW:  pattern[CFG_DATA_BITS-1:0] = data;
				REG_PATTERN_HIGH: pattern[2*CFG_DATA_BITS-1:CFG_DATA_BITS] = data;
				REG_CARE_MASK:    care = data[CARE_BITS-1:0];
				REG_PATTERN_LEN:  len_raw = data[CFG_LEN_BITS-1:0];
				default: ;
			endcase
		endfunction

		// One accepted input beat; queues the result it causes, if any
		function void note_byte(byte_t data, logic last);
			int           i;
			int           k;
			int           len;
			bit           hit;
			count_t       start;
			scan_result_t item;
			len = span();
			if (!matched) begin
				for (i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
				window[0] = data;
				if (seen != COUNT_MAX) seen++;
				hit = (seen >= count_t'(len));
				for (k = 0; k < len; k++) begin
					if (care[k] && window[len-1-k] != pattern_byte(k)) hit = 1'b0;
				end
				if (hit) begin
					matched    = 1'b1;
					start      = seen - count_t'(len);
					item       = '{1'b1, start[MATCH_OFFSET_BITS-1:0]};
					expected_q = {expected_q, item};
					hits++;
				end
			end
			if (last) begin
				if (!matched) begin
					item       = '{1'b0, '0};
					expected_q = {expected_q, item};
					misses++;
				end
				clear_region();
			end
		endfunction

		// One accepted result beat, compared with the oldest expectation
		function void check_result(logic found, logic [MATCH_OFFSET_BITS-1:0] offset);
			scan_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat: found=%0b offset=%0d",
					$time, found, offset);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (found !== want.found) begin
				$display("%0t: found mismatch: expected %0b actual %0b",
					$time, want.found, found);
				errors++;
			end
			if (offset !== want.offset) begin
				$display("%0t: match_offset mismatch: expected %0d actual %0d",
					$time, want.offset, offset);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata;
	logic                      hold_req;
	flow_t                     flow;
	int                        bytes_sent;
	int                        regions_sent;
	int                        settings_used;

	scan_scoreboard sb = new();

	wbps_in_if  in_ch();
	wbps_out_if out_ch();

	wildcard_byte_pattern_scanner u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit src_gap();
		case (flow)
			FLOW_SRC_IDLE: return $urandom_range(99) < SRC_IDLE_PCT;
			FLOW_BOTH:     return $urandom_range(99) < BOTH_PCT;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic bit snk_stall();
		case (flow)
			FLOW_SNK_STALL: return $urandom_range(99) < SNK_STALL_PCT;
			FLOW_BOTH:      return $urandom_range(99) < BOTH_PCT;
			default:        return 1'b0;
		endcase
	endfunction

	// Offer one beat, with random idle cycles ahead of it; returns at the accepting edge
	task automatic push_byte(byte_t data, logic last);
		if (src_gap()) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while (src_gap());
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= data;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_byte(data, last);
		bytes_sent++;
	endtask

	task automatic send_bytes(input byte_t bytes[$], input bit close);
		int i;
		for (i = 0; i < bytes.size(); i++) push_byte(bytes[i], close && i == bytes.size() - 1);
		if (close) regions_sent++;
	endtask

	// Stop offering, wait for every expected result, then let the pipeline empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic write_config(logic [CFG_DATA_BITS-1:0] lo, logic [CFG_DATA_BITS-1:0] hi,
			logic [CARE_BITS-1:0] care, logic [CFG_LEN_BITS-1:0] len);
		put_reg(REG_PATTERN_LOW, lo);
		put_reg(REG_PATTERN_HIGH, hi);
		put_reg(REG_CARE_MASK, CFG_DATA_BITS'(care));
		put_reg(REG_PATTERN_LEN, CFG_DATA_BITS'(len));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Random region: near-miss bytes drawn from the pattern, often with a full match planted
	task automatic random_region();
		byte_t bytes[$];
		int    len;
		int    n;
		int    at;
		int    k;
		len = sb.span();
		case ($urandom_range(19))
			0, 1:    n = (len > 1) ? $urandom_range(len - 1, 1) : 1;
			2:       n = $urandom_range(80, 40);
			default: n = $urandom_range(len + 12, len);
		endcase
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) < 40) bytes = {bytes, sb.pattern_byte($urandom_range(len - 1))};
			else bytes = {bytes, byte_t'($urandom)};
		end
		if (n >= len && $urandom_range(99) < 60) begin
			at = $urandom_range(n - len);
			for (k = 0; k < len; k++) begin
				if (sb.care[k]) bytes[at + k] = sb.pattern_byte(k);
			end
		end
		send_bytes(bytes, 1'b1);
	endtask

	// Result side: checks accepted beats, stalls at random, and serves long hold-offs
	initial begin : result_sink
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.found, out_ch.match_offset);
			if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !snk_stall();
			end
		end
	end

	// Ends the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
			$time, STALL_LIMIT, sb.pending());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		byte_t                bytes[$];
		int                   p;
		int                   r;
		int                   k;
		int                   mark;
		logic [CARE_BITS-1:0] care;
		logic [CFG_DATA_BITS-1:0] lo;
		logic [CFG_DATA_BITS-1:0] hi;
		bytes_sent      = 0;
		regions_sent    = 0;
		settings_used   = 0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_PATTERN_LOW;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.last_byte <= 1'b0;
		hold_req        <= 1'b0;
		flow            <= FLOW_FULL;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one pattern byte 0x00, compared
		bytes = '{8'hFF};
		send_bytes(bytes, 1'b1);                 // no match in region
		bytes = '{8'h00};
		send_bytes(bytes, 1'b1);                 // match on the final byte
		bytes = '{8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF};
		send_bytes(bytes, 1'b1);                 // first match only, tail ignored
		settle();

		// Three-byte pattern 11 22 33
		write_config(64'h0000_0000_0033_2211, '1, '1, 5'd3);
		bytes = '{8'h11, 8'h22};
		send_bytes(bytes, 1'b1);                 // region shorter than pattern
		send_bytes(bytes, 1'b0);                 // open region, then shrink length mid-region
		settle();
		put_reg(REG_PATTERN_LEN, '0);            // zero length counts as one
		cfg_we <= 1'b0;
		bytes = '{8'h11};
		send_bytes(bytes, 1'b1);
		settle();

		// Wildcard in the second pattern byte
		write_config('0, '0, 16'h0001, 5'd2);
		bytes = '{8'h5A, 8'h00, 8'hC3};
		send_bytes(bytes, 1'b1);
		settle();

		// Random phases, each under its own settings and flow pattern
		for (p = 0; p < PHASES; p++) begin
			flow <= flow_t'(p % 4);
			case (p)
				1:       care = '0;
				3:       care = '1;
				default: care = CARE_BITS'($urandom | $urandom);
			endcase
			case (p)
				2:       begin lo = '0; hi = '0; end
				6:       begin lo = '1; hi = '1; end
				default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
			endcase
			write_config(lo, hi, care, LEN_PLAN[p]);
			mark = bytes_sent;
			while (bytes_sent - mark < PHASE_BYTES) random_region();
			settle();

			// Back pressure: result side holds off while short matching regions keep coming
			if (p == 4) begin
				flow <= FLOW_FULL;
				write_config({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd1);
				hold_req <= 1'b1;
				for (r = 0; r < 20; r++) begin
					bytes.delete();
					for (k = $urandom_range(3, 1); k > 0; k--) bytes = {bytes, byte_t'($urandom)};
					send_bytes(bytes, 1'b1);
				end
				hold_req <= 1'b0;
				settle();
			end
		end

		$display("covered %0d bytes in %0d regions under %0d register settings",
			bytes_sent, regions_sent, settings_used);
		$display("predicted %0d matches and %0d regions without a match, %0d mismatches",
			sb.hits, sb.misses, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
